[sv/rope3_pkg.sv]
`default_nettype none

package rope3_pkg;

  localparam int unsigned MaxTokens  = 16384;
  localparam int unsigned NumFreqs   = 64;
  localparam int unsigned FreqAw     = $clog2(NumFreqs);
  localparam int unsigned Axis1Start = 16;
  localparam int unsigned Axis2Start = 40;

  localparam int unsigned TokW     = 14;
  localparam int unsigned GridW    = 9;
  localparam int unsigned TextW    = 12;
  localparam int unsigned ImageW   = 2 * GridW;
  localparam int unsigned LenW     = ImageW + 1;
  localparam int unsigned PosW     = 12;
  localparam int unsigned FreqW    = 32;
  localparam int unsigned PhaseW   = 32;
  localparam int unsigned XW       = 31;
  localparam int unsigned OutW     = 16;
  localparam int unsigned PairW    = 6;
  localparam int unsigned IdxInW   = 6;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned SineLat  = 7;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned DivSteps = TokW;

  localparam logic [CfgIdxW-1:0] RegGridWidth  = 8'd0;
  localparam logic [CfgIdxW-1:0] RegGridHeight = 8'd1;
  localparam logic [CfgIdxW-1:0] RegValidText  = 8'd2;
  localparam logic [CfgIdxW-1:0] RegTextTokens = 8'd3;

  // Quarter-wave sine polynomial, Q2.30 coefficients, innermost first.
  localparam logic [31:0] SinC0 = 32'd172272;
  localparam logic [31:0] SinC1 = 32'd5026995;
  localparam logic [31:0] SinC2 = 32'd85569306;
  localparam logic [31:0] SinC3 = 32'd693598668;
  localparam logic [31:0] SinC4 = 32'd1686629713;
  localparam logic [XW-1:0] Quarter = 31'h4000_0000;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_GEN,
    CMD_BAD
  } cmd_e;

  typedef struct packed {
    logic [GridW-1:0] grid_width;
    logic [GridW-1:0] grid_height;
    logic [TextW-1:0] valid_text;
    logic [TextW-1:0] text_tokens;
  } cfg_t;

  typedef struct packed {
    cmd_e              kind;
    logic [FreqAw-1:0] idx;
    logic [FreqW-1:0]  value;
    logic              masked;
    logic [PosW-1:0]   pos0;
    logic [GridW-1:0]  pos1;
    logic [GridW-1:0]  pos2;
  } cmd_t;

  typedef struct packed {
    logic              valid;
    logic              bad;
    logic              last;
    logic              masked;
    logic [FreqAw-1:0] j;
    logic [1:0]        quad;
  } sb_t;

endpackage

`default_nettype wire

[sv/rope3_ram.sv]
`default_nettype none

module rope3_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[sv/rope3_fifo.sv]
`default_nettype none

module rope3_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  output logic                 push_ready_o,
  input  rope3_pkg::cmd_t      push_data_i,
  output logic                 pop_valid_o,
  input  wire logic            pop_ready_i,
  output rope3_pkg::cmd_t      pop_data_o
);

  localparam int unsigned PtrW = $clog2(rope3_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(rope3_pkg::QueueDepth + 1);

  rope3_pkg::cmd_t   slot_q [rope3_pkg::QueueDepth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;
  logic              push, pop;

  assign push_ready_o = (cnt_q != CntW'(rope3_pkg::QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = slot_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[sv/rope3_front.sv]
`default_nettype none

module rope3_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  rope3_pkg::cfg_t                    cfg_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          op_i,
  input  wire logic [rope3_pkg::IdxInW-1:0]  freq_index_i,
  input  wire logic [rope3_pkg::FreqW-1:0]   freq_value_i,
  input  wire logic [rope3_pkg::TokW-1:0]    token_index_i,
  output logic                               push_valid_o,
  input  wire logic                          push_ready_i,
  output rope3_pkg::cmd_t                    push_data_o
);

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_CMP,
    F_DIV,
    F_PUSH
  } fstate_e;

  localparam int unsigned CntW = $clog2(rope3_pkg::DivSteps);

  fstate_e                          state_q;
  logic [rope3_pkg::TokW-1:0]       tok_q;
  logic [rope3_pkg::ImageW-1:0]     image_q;
  logic [rope3_pkg::TokW-1:0]       quo_q;
  logic [rope3_pkg::GridW-1:0]      rem_q;
  logic [CntW-1:0]                  cnt_q;
  rope3_pkg::cmd_t                  cmd_q;

  logic [rope3_pkg::LenW-1:0]       length, mask_limit;
  logic [rope3_pkg::LenW-1:0]       tok_ext;
  logic                             is_bad, is_image;
  logic [rope3_pkg::GridW:0]        rem_sh;
  logic                             ge;

  assign in_ready_o   = (state_q == F_IDLE);
  // The row and column are copied in during the first push cycle of an image token.
  assign push_valid_o = (state_q == F_PUSH) &&
                        !(cmd_q.kind == rope3_pkg::CMD_GEN && cnt_q != '0);
  assign push_data_o  = cmd_q;

  always_comb begin
    tok_ext    = rope3_pkg::LenW'(tok_q);
    length     = rope3_pkg::LenW'(image_q) + rope3_pkg::LenW'(cfg_i.text_tokens);
    mask_limit = rope3_pkg::LenW'(image_q) + rope3_pkg::LenW'(cfg_i.valid_text);
    is_bad     = (tok_ext >= length) || (32'(tok_q) >= rope3_pkg::MaxTokens);
    is_image   = (tok_ext < rope3_pkg::LenW'(image_q));
    // One restoring division step: the remainder always stays below the width.
    rem_sh     = {rem_q, quo_q[rope3_pkg::TokW-1]};
    ge         = (rem_sh >= {1'b0, cfg_i.grid_width});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (in_valid_i) begin
            tok_q            <= token_index_i;
            cmd_q.kind       <= rope3_pkg::CMD_LOAD;
            cmd_q.idx        <= rope3_pkg::FreqAw'(freq_index_i);
            cmd_q.value      <= freq_value_i;
            if (op_i) begin
              state_q <= F_MUL;
            end else if (32'(freq_index_i) < rope3_pkg::NumFreqs) begin
              state_q <= F_PUSH;
            end
          end
        end
        F_MUL: begin
          image_q <= rope3_pkg::ImageW'(cfg_i.grid_width) *
                     rope3_pkg::ImageW'(cfg_i.grid_height);
          state_q <= F_CMP;
        end
        F_CMP: begin
          cmd_q.masked <= (tok_ext >= mask_limit);
          cmd_q.pos1   <= '0;
          cmd_q.pos2   <= '0;
          if (is_bad) begin
            cmd_q.kind <= rope3_pkg::CMD_BAD;
            state_q    <= F_PUSH;
          end else begin
            cmd_q.kind <= rope3_pkg::CMD_GEN;
            if (is_image) begin
              cmd_q.pos0 <= cfg_i.valid_text;
              quo_q      <= tok_q;
              rem_q      <= '0;
              cnt_q      <= '0;
              state_q    <= F_DIV;
            end else begin
              cmd_q.pos0 <= rope3_pkg::PosW'(tok_ext - rope3_pkg::LenW'(image_q));
              state_q    <= F_PUSH;
            end
          end
        end
        F_DIV: begin
          quo_q <= {quo_q[rope3_pkg::TokW-2:0], ge};
          rem_q <= ge ? rope3_pkg::GridW'(rem_sh - {1'b0, cfg_i.grid_width})
                      : rope3_pkg::GridW'(rem_sh);
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(rope3_pkg::DivSteps - 1)) begin
            state_q <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (cmd_q.kind == rope3_pkg::CMD_GEN && cnt_q != '0) begin
            cmd_q.pos1 <= rope3_pkg::GridW'(quo_q);
            cmd_q.pos2 <= rem_q;
            cnt_q      <= '0;
          end else if (push_ready_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/rope3_sine.sv]
`default_nettype none

module rope3_sine (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic [rope3_pkg::XW-1:0] x_i,
  output logic      [14:0]              y_o
);

  logic [rope3_pkg::XW-1:0] xs_q [5];
  logic [rope3_pkg::XW-1:0] x2_q [4];
  logic [31:0]              t1_q, t2_q, t3_q, t4_q, p_q;
  logic [32:0]              rnd;

  function automatic logic [31:0] horner(input logic [rope3_pkg::XW-1:0] x2,
                                         input logic [31:0] t,
                                         input logic [31:0] c);
    logic [63:0] prod;
    prod = 64'(x2) * 64'(t);
    return c - 32'(prod >> 30);
  endfunction

  assign rnd = 33'(p_q) + 33'd16384;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xs_q[0] <= x_i;
      x2_q[0] <= rope3_pkg::XW'((64'(x_i) * 64'(x_i)) >> 30);
      xs_q[1] <= xs_q[0];
      x2_q[1] <= x2_q[0];
      t1_q    <= horner(x2_q[0], rope3_pkg::SinC0, rope3_pkg::SinC1);
      xs_q[2] <= xs_q[1];
      x2_q[2] <= x2_q[1];
      t2_q    <= horner(x2_q[1], t1_q, rope3_pkg::SinC2);
      xs_q[3] <= xs_q[2];
      x2_q[3] <= x2_q[2];
      t3_q    <= horner(x2_q[2], t2_q, rope3_pkg::SinC3);
      xs_q[4] <= xs_q[3];
      t4_q    <= horner(x2_q[3], t3_q, rope3_pkg::SinC4);
      p_q     <= 32'((64'(xs_q[4]) * 64'(t4_q)) >> 30);
      // Round half up to unsigned Q0.15 and saturate at the largest positive code.
      y_o     <= (rnd[32:15] > 18'd32767) ? 15'h7FFF : rnd[29:15];
    end
  end

endmodule

`default_nettype wire

[sv/rope3_back.sv]
`default_nettype none

module rope3_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          pop_valid_i,
  output logic                               pop_ready_o,
  input  rope3_pkg::cmd_t                    pop_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [rope3_pkg::PairW-1:0]        pair_index_o,
  output logic signed [rope3_pkg::OutW-1:0]  cos_value_o,
  output logic signed [rope3_pkg::OutW-1:0]  sin_value_o,
  output logic                               masked_o,
  output logic                               bad_token_o,
  output logic                               last_o
);

  typedef enum logic {
    B_IDLE,
    B_RUN
  } bstate_e;

  localparam int unsigned FAw = rope3_pkg::FreqAw;

  bstate_e                        state_q;
  logic [FAw-1:0]                 j_q;
  logic [rope3_pkg::PosW-1:0]     p0_q;
  logic [rope3_pkg::GridW-1:0]    p1_q, p2_q;
  logic                           masked_q;

  logic                           en, pop;
  rope3_pkg::sb_t                 iss, sb1_q, sb2_q, dl_in;
  rope3_pkg::sb_t                 dl_q [rope3_pkg::SineLat];
  logic [rope3_pkg::PosW-1:0]     iss_pos, pos1_q;
  logic [rope3_pkg::FreqW-1:0]    rd_data;
  logic [rope3_pkg::PhaseW-1:0]   phase_q;
  logic [rope3_pkg::XW-1:0]       xa, xb;
  logic [14:0]                    sa, sb;
  logic [rope3_pkg::OutW-1:0]     pa, pb, na, nb;
  rope3_pkg::sb_t                 tail;

  // The whole pipe advances together whenever the output register can move.
  assign en          = out_ready_i || !out_valid_o;
  assign pop_ready_o = (state_q == B_IDLE) && en;
  assign pop         = pop_valid_i && pop_ready_o;

  always_comb begin
    iss      = '0;
    iss_pos  = '0;
    if (state_q == B_RUN) begin
      iss.valid  = 1'b1;
      iss.j      = j_q;
      iss.masked = masked_q;
      iss.last   = (32'(j_q) == rope3_pkg::NumFreqs - 1);
    end else if (pop && pop_data_i.kind == rope3_pkg::CMD_BAD) begin
      iss.valid = 1'b1;
      iss.bad   = 1'b1;
      iss.last  = 1'b1;
    end
    if (32'(j_q) < rope3_pkg::Axis1Start) begin
      iss_pos = p0_q;
    end else if (32'(j_q) < rope3_pkg::Axis2Start) begin
      iss_pos = rope3_pkg::PosW'(p1_q);
    end else begin
      iss_pos = rope3_pkg::PosW'(p2_q);
    end
  end

  rope3_ram #(
    .Width (rope3_pkg::FreqW),
    .Depth (rope3_pkg::NumFreqs)
  ) u_freq_ram (
    .clk_i   (clk_i),
    .we_i    (pop && pop_data_i.kind == rope3_pkg::CMD_LOAD),
    .waddr_i (pop_data_i.idx),
    .wdata_i (pop_data_i.value),
    .re_i    (en),
    .raddr_i (j_q),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      j_q     <= '0;
    end else begin
      unique case (state_q)
        B_IDLE: begin
          if (pop && pop_data_i.kind == rope3_pkg::CMD_GEN) begin
            p0_q     <= pop_data_i.pos0;
            p1_q     <= pop_data_i.pos1;
            p2_q     <= pop_data_i.pos2;
            masked_q <= pop_data_i.masked;
            j_q      <= '0;
            state_q  <= B_RUN;
          end
        end
        B_RUN: begin
          if (en) begin
            if (32'(j_q) == rope3_pkg::NumFreqs - 1) begin
              j_q     <= '0;
              state_q <= B_IDLE;
            end else begin
              j_q <= j_q + 1'b1;
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign xa = rope3_pkg::XW'(phase_q[29:0]);
  assign xb = rope3_pkg::Quarter - xa;

  rope3_sine u_sine_a (.clk_i(clk_i), .en_i(en), .x_i(xa), .y_o(sa));
  rope3_sine u_sine_b (.clk_i(clk_i), .en_i(en), .x_i(xb), .y_o(sb));

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos1_q  <= iss_pos;
      phase_q <= rope3_pkg::PhaseW'(44'(pos1_q) * 44'(rd_data));
    end
  end

  always_comb begin
    dl_in      = sb2_q;
    dl_in.quad = phase_q[31:30];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb1_q <= '0;
      sb2_q <= '0;
      for (int k = 0; k < rope3_pkg::SineLat; k++) begin
        dl_q[k] <= '0;
      end
    end else if (en) begin
      sb1_q      <= iss;
      sb2_q      <= sb1_q;
      dl_q[0]    <= dl_in;
      for (int k = 1; k < rope3_pkg::SineLat; k++) begin
        dl_q[k] <= dl_q[k-1];
      end
    end
  end

  assign tail = dl_q[rope3_pkg::SineLat-1];
  assign pa   = rope3_pkg::OutW'(sa);
  assign pb   = rope3_pkg::OutW'(sb);
  assign na   = '0 - pa;
  assign nb   = '0 - pb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= tail.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pair_index_o <= rope3_pkg::PairW'(tail.j);
      masked_o     <= tail.masked;
      bad_token_o  <= tail.bad;
      last_o       <= tail.last;
      if (tail.bad) begin
        cos_value_o <= '0;
        sin_value_o <= '0;
      end else begin
        case (tail.quad)
          2'd0:    begin sin_value_o <= pa; cos_value_o <= pb; end
          2'd1:    begin sin_value_o <= pb; cos_value_o <= na; end
          2'd2:    begin sin_value_o <= na; cos_value_o <= nb; end
          default: begin sin_value_o <= nb; cos_value_o <= pa; end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[sv/rope_3axis_table_generator.sv]
// A generate item is classified by the front (image tokens also pass the row/column divider),
// then the back issues its pairs, reading the frequency RAM once per pair and giving one
// result per cycle while the output is not stalled. The back takes no new item until the last
// pair of the current one has issued; the front can classify the next item during a run.
// Reset: asynchronous, active low; registers return to 1, queue and pipeline empty.
// The frequency table is not cleared and must be loaded before use.
`default_nettype none

module rope_3axis_table_generator (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [rope3_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [rope3_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            op_i,
  input  wire logic [rope3_pkg::IdxInW-1:0]    freq_index_i,
  input  wire logic [rope3_pkg::FreqW-1:0]     freq_value_i,
  input  wire logic [rope3_pkg::TokW-1:0]      token_index_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [rope3_pkg::PairW-1:0]          pair_index_o,
  output logic signed [rope3_pkg::OutW-1:0]    cos_value_o,
  output logic signed [rope3_pkg::OutW-1:0]    sin_value_o,
  output logic                                 masked_o,
  output logic                                 bad_token_o,
  output logic                                 last_o
);

  rope3_pkg::cfg_t cfg_q;
  rope3_pkg::cmd_t push_data, pop_data;
  logic            push_valid, push_ready, pop_valid, pop_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_width  <= rope3_pkg::GridW'(1);
      cfg_q.grid_height <= rope3_pkg::GridW'(1);
      cfg_q.valid_text  <= rope3_pkg::TextW'(1);
      cfg_q.text_tokens <= rope3_pkg::TextW'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rope3_pkg::RegGridWidth:  cfg_q.grid_width  <= cfg_data_i[rope3_pkg::GridW-1:0];
        rope3_pkg::RegGridHeight: cfg_q.grid_height <= cfg_data_i[rope3_pkg::GridW-1:0];
        rope3_pkg::RegValidText:  cfg_q.valid_text  <= cfg_data_i[rope3_pkg::TextW-1:0];
        rope3_pkg::RegTextTokens: cfg_q.text_tokens <= cfg_data_i[rope3_pkg::TextW-1:0];
        default: ;
      endcase
    end
  end

  rope3_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .freq_index_i  (freq_index_i),
    .freq_value_i  (freq_value_i),
    .token_index_i (token_index_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_data_o   (push_data)
  );

  rope3_fifo u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  rope3_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_data_i   (pop_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pair_index_o (pair_index_o),
    .cos_value_o  (cos_value_o),
    .sin_value_o  (sin_value_o),
    .masked_o     (masked_o),
    .bad_token_o  (bad_token_o),
    .last_o       (last_o)
  );

`ifndef ASSERT_OFF
  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_token_o |-> last_o)
    else $error("error result is not marked last");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_token_o |-> pair_index_o == '0 && cos_value_o == '0
                                   && sin_value_o == '0 && !masked_o)
    else $error("error result carries a non-zero payload");

  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("front accepted an item without leaving idle");
`endif

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_GEN  = 1'b1;

  typedef struct {
    logic [rope3_pkg::PairW-1:0] pair;
    logic [rope3_pkg::OutW-1:0]  cos_v;
    logic [rope3_pkg::OutW-1:0]  sin_v;
    logic                        masked;
    logic                        bad;
    logic                        last;
  } pair_t;

  class rope_sb;
    bit [rope3_pkg::FreqW-1:0] freq_tab [rope3_pkg::NumFreqs];
    bit [rope3_pkg::GridW-1:0] gw = 1, gh = 1;
    bit [rope3_pkg::TextW-1:0] vt = 1, tt = 1;
    pair_t          pending [$];
    int             errors;
    int             checked;
    int             gen_items;
    int             bad_items;

    function bit [15:0] quarter_sine(bit [31:0] x);
      longint unsigned xv, x2, t, s;
      xv = x;
      x2 = (xv * xv) >> 30;
      t  = rope3_pkg::SinC0;
      t  = rope3_pkg::SinC1 - ((x2 * t) >> 30);
      t  = rope3_pkg::SinC2 - ((x2 * t) >> 30);
      t  = rope3_pkg::SinC3 - ((x2 * t) >> 30);
      t  = rope3_pkg::SinC4 - ((x2 * t) >> 30);
      s  = (xv * t) >> 30;
      s  = (s + 16384) >> 15;
      if (s > 32767) s = 32767;
      return s[15:0];
    endfunction

    function void set_reg(logic [rope3_pkg::CfgIdxW-1:0] idx,
                          logic [rope3_pkg::CfgDataW-1:0] data);
      case (idx)
        rope3_pkg::RegGridWidth:  gw = data[rope3_pkg::GridW-1:0];
        rope3_pkg::RegGridHeight: gh = data[rope3_pkg::GridW-1:0];
        rope3_pkg::RegValidText:  vt = data[rope3_pkg::TextW-1:0];
        rope3_pkg::RegTextTokens: tt = data[rope3_pkg::TextW-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(logic op, logic [5:0] fi, logic [31:0] fv,
                            logic [rope3_pkg::TokW-1:0] tok);
      bit [31:0] image, length, ph, r;
      bit [31:0] pos [3];
      bit [15:0] a, b;
      bit        msk;
      pair_t     e;
      if (op == OP_LOAD) begin
        if (fi < rope3_pkg::NumFreqs) freq_tab[fi] = fv;
        return;
      end
      gen_items++;
      image  = gw * gh;
      length = image + tt;
      if (tok >= length || tok >= rope3_pkg::MaxTokens) begin
        bad_items++;
        e = '{pair: '0, cos_v: '0, sin_v: '0, masked: 1'b0, bad: 1'b1, last: 1'b1};
        pending.push_back(e);
        return;
      end
      if (tok < image) begin
        pos[0] = vt;
        pos[1] = tok / gw;
        pos[2] = tok % gw;
      end else begin
        pos[0] = tok - image;
        pos[1] = 0;
        pos[2] = 0;
      end
      msk = (tok >= image + vt);
      for (int j = 0; j < rope3_pkg::NumFreqs; j++) begin
        ph = pos[j < rope3_pkg::Axis1Start ? 0 : (j < rope3_pkg::Axis2Start ? 1 : 2)]
             * freq_tab[j];
        r  = {2'b00, ph[29:0]};
        a  = quarter_sine(r);
        b  = quarter_sine(32'h4000_0000 - r);
        e.pair = j[rope3_pkg::PairW-1:0];
        case (ph[31:30])
          2'd0: begin e.sin_v = a;  e.cos_v = b;  end
          2'd1: begin e.sin_v = b;  e.cos_v = -a; end
          2'd2: begin e.sin_v = -a; e.cos_v = -b; end
          default: begin e.sin_v = -b; e.cos_v = a; end
        endcase
        e.masked = msk;
        e.bad    = 1'b0;
        e.last   = (j == rope3_pkg::NumFreqs - 1);
        pending.push_back(e);
      end
    endfunction

    function void check_pair(pair_t got);
      pair_t e;
      if (pending.size() == 0) begin
        $error("unexpected result: pair %0d", got.pair);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.pair !== e.pair) begin
        $error("pair_index: expected %0d, got %0d", e.pair, got.pair); errors++;
      end
      if (got.cos_v !== e.cos_v) begin
        $error("cos_value: expected %0d, got %0d", $signed(e.cos_v), $signed(got.cos_v));
        errors++;
      end
      if (got.sin_v !== e.sin_v) begin
        $error("sin_value: expected %0d, got %0d", $signed(e.sin_v), $signed(got.sin_v));
        errors++;
      end
      if (got.masked !== e.masked) begin
        $error("masked: expected %0b, got %0b", e.masked, got.masked); errors++;
      end
      if (got.bad !== e.bad) begin
        $error("bad_token: expected %0b, got %0b", e.bad, got.bad); errors++;
      end
      if (got.last !== e.last) begin
        $error("last: expected %0b, got %0b", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic                            clk_i, rst_ni;
  logic                            cfg_valid_i, cfg_ready_o;
  logic [rope3_pkg::CfgIdxW-1:0]   cfg_index_i;
  logic [rope3_pkg::CfgDataW-1:0]  cfg_data_i;
  logic                            in_valid_i, in_ready_o;
  logic                            op_i;
  logic [rope3_pkg::IdxInW-1:0]    freq_index_i;
  logic [rope3_pkg::FreqW-1:0]     freq_value_i;
  logic [rope3_pkg::TokW-1:0]      token_index_i;
  logic                            out_valid_o, out_ready_i;
  logic [rope3_pkg::PairW-1:0]     pair_index_o;
  logic signed [rope3_pkg::OutW-1:0] cos_value_o, sin_value_o;
  logic                            masked_o, bad_token_o, last_o;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  rope_sb      sb = new;

  rope_3axis_table_generator u_dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .op_i, .freq_index_i, .freq_value_i, .token_index_i,
    .out_valid_o, .out_ready_i, .pair_index_o, .cos_value_o, .sin_value_o,
    .masked_o, .bad_token_o, .last_o
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("tb_top: done, errors");
    $finish;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Outputs are stable at the falling edge, so a handshake seen here completes at the next rise.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_pair('{pair: pair_index_o, cos_v: cos_value_o, sin_v: sin_value_o,
                      masked: masked_o, bad: bad_token_o, last: last_o});
    end
  end

  // Called at a rising edge; returns at the rising edge that accepts the item.
  task automatic send_item(logic op, logic [5:0] fi, logic [31:0] fv,
                           logic [rope3_pkg::TokW-1:0] tok);
    logic rdy;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    freq_index_i  <= fi;
    freq_value_i  <= fv;
    token_index_i <= tok;
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    sb.note_item(op, fi, fv, tok);
  endtask

  task automatic write_reg(logic [rope3_pkg::CfgIdxW-1:0] idx,
                           logic [rope3_pkg::CfgDataW-1:0] data);
    logic rdy;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(negedge clk_i);
      rdy = cfg_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    cfg_valid_i <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  // Drains every expected result, then allows for a load still in flight.
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_grid(int unsigned w, int unsigned h, int unsigned v, int unsigned t);
    // Upper bits are junk that the block must discard.
    write_reg(rope3_pkg::RegGridWidth,  {$urandom} << rope3_pkg::GridW | w);
    write_reg(rope3_pkg::RegGridHeight, {$urandom} << rope3_pkg::GridW | h);
    write_reg(rope3_pkg::RegValidText,  {$urandom} << rope3_pkg::TextW | v);
    write_reg(rope3_pkg::RegTextTokens, {$urandom} << rope3_pkg::TextW | t);
  endtask

  function automatic logic [31:0] pick_freq();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(65535);
      3: return 32'h4000_0000 >> $urandom_range(20);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [rope3_pkg::TokW-1:0] pick_token();
    int unsigned image, length, r, tok;
    image  = sb.gw * sb.gh;
    length = image + sb.tt;
    r = $urandom_range(99);
    if (r < 12) tok = length + $urandom_range(40);
    else if (r < 50 && image > 0) tok = $urandom_range((image > 16384 ? 16384 : image) - 1);
    else tok = image + $urandom_range(sb.tt - 1 < 0 ? 0 : sb.tt - 1);
    if (tok > 16383) tok = $urandom_range(16383);
    return tok[rope3_pkg::TokW-1:0];
  endfunction

  int unsigned grids [7][4] = '{
    '{1, 1, 1, 1}, '{256, 256, 2048, 2048}, '{0, 7, 3, 20}, '{13, 5, 5, 40},
    '{511, 511, 4095, 4095}, '{1, 1, 2048, 1}, '{256, 1, 1, 2048}
  };
  int unsigned idle_modes [4][2] = '{'{0, 0}, '{83, 0}, '{0, 83}, '{32, 32}};

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    in_valid_i = 1'b0; op_i = 1'b0; freq_index_i = '0; freq_value_i = '0;
    token_index_i = '0; out_ready_i = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the whole table first so that no generate ever reads an unwritten entry.
    for (int i = 0; i < rope3_pkg::NumFreqs; i++) begin
      logic [31:0] f;
      case (i)
        0: f = 32'h0;
        1: f = 32'hFFFF_FFFF;
        2: f = 32'h4000_0000;
        3: f = 32'h8000_0000;
        4: f = 32'hC000_0000;
        5: f = 32'h0000_0001;
        default: f = pick_freq();
      endcase
      send_item(OP_LOAD, i[5:0], f, $urandom);
    end

    // Reset grid: one image token, one text token, out-of-range tokens, then a reload of entry 63 and a text token.
    send_item(OP_GEN, $urandom, $urandom, 14'd0);
    send_item(OP_GEN, $urandom, $urandom, 14'd1);
    send_item(OP_GEN, $urandom, $urandom, 14'd2);
    send_item(OP_GEN, $urandom, $urandom, 14'h3FFF);
    send_item(OP_LOAD, 6'd63, 32'hFFFF_FFFF, 14'h3FFF);
    send_item(OP_GEN, 6'd63, 32'hFFFF_FFFF, 14'd1);
    wait_quiet();

    for (int g = 0; g < 7; g++) begin
      if (g != 0) set_grid(grids[g][0], grids[g][1], grids[g][2], grids[g][3]);
      for (int m = 0; m < 4; m++) begin
        send_idle_pct  = idle_modes[m][0];
        recv_stall_pct = idle_modes[m][1];
        for (int k = 0; k < 7; k++) begin
          if ($urandom_range(99) < 15) send_item(OP_LOAD, $urandom, pick_freq(), $urandom);
          else send_item(OP_GEN, $urandom, $urandom, pick_token());
        end
      end
      wait_quiet();
    end

    repeat (100) @(posedge clk_i);
    $display("Covered %0d generate items (%0d out of range) over 7 grid settings,",
             sb.gen_items, sb.bad_items);
    $display("with %0d results checked under four idle and stall patterns.", sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
